@@ design/slie_pkg.sv @@
// Shared types and constants for the sorted list intersect / except block.
// Depends on nothing; imported by the controller, the datapath and the top level.
package slie_pkg;

   localparam int RES_ID_BITS = 24;
   localparam int COUNT_BITS  = 6;
   localparam int OP_BITS     = 2;

   localparam logic MODE_INTERSECT = 1'b0;
   localparam logic MODE_EXCEPT    = 1'b1;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD_FIRST  = 2'd0,
      OP_LOAD_SECOND = 2'd1,
      OP_RUN         = 2'd2
   } op_type;

   typedef struct packed {
      logic start;
      logic load_first;
      logic load_second;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic can_push;
   } status_type;

endpackage

@@ design/slie_ctrl.sv @@
// Controller state machine: takes input words, decodes op and sequences a run.
// Depends on slie_pkg for op codes and the command / status structs.
module slie_ctrl
   import slie_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [OP_BITS-1:0]  req_tuser,
   output logic                req_tready,
   input  status_type          status,
   output cmd_type             cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (op_type'(req_tuser))
                  OP_LOAD_FIRST:  cmd.load_first  = 1'b1;
                  OP_LOAD_SECOND: cmd.load_second = 1'b1;
                  OP_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = status.can_push;
            end
         end
         ST_FINISH: begin
            if (status.can_push) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/slie_dp.sv @@
// Datapath: list memories, lengths, merge indices, pending result and output word.
// Depends on slie_pkg; driven by commands from slie_ctrl.
module slie_dp
   import slie_pkg::*;
#(
   parameter int LIST_DEPTH = 32,
   parameter int ID_BITS    = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [RES_ID_BITS-1:0]  doc_id,
   input  logic                    csr_we,
   input  logic                    csr_wdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast
);

   localparam int AW    = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   logic [ID_BITS-1:0] first_mem  [LIST_DEPTH];
   logic [ID_BITS-1:0] second_mem [LIST_DEPTH];

   logic                   mode_ff;
   logic [CNT_W-1:0]       first_len_ff, second_len_ff;
   logic                   overflow_ff;
   logic [CNT_W-1:0]       i_ff, i_in, j_ff, j_in;
   logic [ID_BITS-1:0]     a_ff, b_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   pend_valid_ff;
   logic [ID_BITS-1:0]     pend_id_ff;
   logic [CNT_W-1:0]       pend_cnt_ff;
   logic                   out_valid_ff;
   logic [RES_ID_BITS-1:0] out_id_ff;
   logic                   out_res_ff, out_last_ff, out_drop_ff;
   logic [COUNT_BITS-1:0]  out_cnt_ff;

   logic [ID_BITS+RES_ID_BITS-1:0] load_ext;
   logic [ID_BITS-1:0]             load_id;
   logic [RES_ID_BITS+ID_BITS-1:0] pend_id_ext;
   logic [COUNT_BITS+CNT_W-1:0]    pend_cnt_ext;
   logic i_lt, j_lt, both, emit, adv_i, adv_j, push;

   assign load_ext     = {{ID_BITS{1'b0}}, doc_id};
   assign load_id      = load_ext[ID_BITS-1:0];
   assign pend_id_ext  = {{RES_ID_BITS{1'b0}}, pend_id_ff};
   assign pend_cnt_ext = {{COUNT_BITS{1'b0}}, pend_cnt_ff};

   // one merge step decision on the current heads
   always_comb begin
      i_lt  = (i_ff < first_len_ff);
      j_lt  = (j_ff < second_len_ff);
      both  = i_lt && j_lt;
      emit  = 1'b0;
      adv_i = 1'b0;
      adv_j = 1'b0;
      if (both) begin
         if (a_ff < b_ff) begin
            emit  = (mode_ff == MODE_EXCEPT);
            adv_i = 1'b1;
         end else if (a_ff > b_ff) begin
            adv_j = 1'b1;
         end else begin
            emit  = (mode_ff == MODE_INTERSECT);
            adv_j = (mode_ff == MODE_INTERSECT);
            adv_i = 1'b1;
         end
      end else if ((mode_ff == MODE_EXCEPT) && i_lt) begin
         emit  = 1'b1;
         adv_i = 1'b1;
      end
   end

   assign status.walk_done = !(both || ((mode_ff == MODE_EXCEPT) && i_lt));
   assign status.can_push  = !out_valid_ff || rsp_tready;

   // a step that emits flushes the older pending id; finish flushes the last
   assign push = (cmd.step && emit && pend_valid_ff) || cmd.finish;

   always_comb begin
      if (cmd.start) begin
         i_in = '0;
         j_in = '0;
      end else begin
         i_in = (cmd.step && adv_i) ? i_ff + ONE_C : i_ff;
         j_in = (cmd.step && adv_j) ? j_ff + ONE_C : j_ff;
      end
   end

   // list memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (cmd.load_first && (first_len_ff < DEPTH_C)) begin
         first_mem[first_len_ff[AW-1:0]] <= load_id;
      end
      a_ff <= first_mem[i_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_second && (second_len_ff < DEPTH_C)) begin
         second_mem[second_len_ff[AW-1:0]] <= load_id;
      end
      b_ff <= second_mem[j_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      if (cmd.start) begin
         cnt_ff <= '0;
      end else if (cmd.step && emit) begin
         cnt_ff      <= cnt_ff + ONE_C;
         pend_id_ff  <= a_ff;
         pend_cnt_ff <= cnt_ff + ONE_C;
      end
      if (push) begin
         out_last_ff <= cmd.finish;
         out_drop_ff <= overflow_ff;
         if (cmd.finish && !pend_valid_ff) begin
            out_id_ff  <= '0;
            out_res_ff <= 1'b0;
            out_cnt_ff <= '0;
         end else begin
            out_id_ff  <= pend_id_ext[RES_ID_BITS-1:0];
            out_res_ff <= 1'b1;
            out_cnt_ff <= pend_cnt_ext[COUNT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_INTERSECT;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         overflow_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         if (cmd.load_first) begin
            if (first_len_ff < DEPTH_C) begin
               first_len_ff <= first_len_ff + ONE_C;
            end else begin
               overflow_ff <= 1'b1;
            end
         end
         if (cmd.load_second) begin
            if (second_len_ff < DEPTH_C) begin
               second_len_ff <= second_len_ff + ONE_C;
            end else begin
               overflow_ff <= 1'b1;
            end
         end
         if (cmd.start || cmd.finish) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.step && emit) begin
            pend_valid_ff <= 1'b1;
         end
         if (cmd.finish) begin
            first_len_ff  <= '0;
            second_len_ff <= '0;
            overflow_ff   <= 1'b0;
         end
         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_cnt_ff, out_id_ff};
   assign rsp_tuser  = {out_drop_ff, out_res_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

@@ design/sorted_list_intersect_except_top.sv @@
// Top level of the sorted list intersect / except block.
// Depends on slie_pkg, slie_ctrl and slie_dp.
//
// Usage:
//   req_* carries load and run words. req_tuser is the op: load the id in
//   req_tdata into the first list, load it into the second list, or run the
//   merge. Code 3 is taken and ignored. csr_we / csr_wdata write the mode
//   (0 intersection, 1 first list minus second); write it only while idle.
//   rsp_* carries one word per result id in ascending order, with a running
//   count and rsp_tlast on the final word. An empty result gives one word with
//   valid_res low, count 0 and tlast high.
// Sequence:
//   Loads stream back to back. A run is accepted, then walks the merge one
//   step at a time (at most first length plus second length steps), sees the
//   walk done and pushes the last word. The merge loop runs one step a cycle
//   on the single read port of each list memory while the output can take a
//   word. No new word is taken until that push.
// Reset and stall:
//   Reset empties both lists, clears the overflow flag and selects
//   intersection; list memories need no clearing pass. A stalled receiver
//   holds the output word and the walk waits until it drains; the input side
//   is taken again as soon as the final word sits in the output register.
module sorted_list_intersect_except_top
   import slie_pkg::*;
#(
   parameter int LIST_DEPTH = 32,
   parameter int ID_BITS    = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] doc_id
   input  logic [1:0]  req_tuser,   // [1:0] op
   input  logic        csr_we,
   input  logic        csr_wdata,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [23:0] result_id, [29:24] count, [31:30] zero
   output logic [1:0]  rsp_tuser,   // [0] valid_res, [1] dropped
   output logic        rsp_tlast    // last
);

   cmd_type    cmd;
   status_type status;

   // sequence loads and runs
   slie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold the lists, walk them and drive the output word
   slie_dp #(
      .LIST_DEPTH (LIST_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .doc_id     (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // no input word is taken while a run is walking or finishing
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.finish) |-> !req_tready)
      else $error("input taken during a run");

   // finishing a run leaves the last word in the output register
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_tvalid && rsp_tlast))
      else $error("run finished without a last word");

   // an empty result word carries a zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tlast && (rsp_tdata[29:24] == 6'd0)))
      else $error("empty result word malformed");

endmodule
